### hw/rtl/toroidal_life_automaton_assert.svh
// Assertion macros shared by the RTL. Every macro samples on clk and
// stays quiet while rst_n is low.
`ifndef TOROIDAL_LIFE_AUTOMATON_ASSERT_SVH
`define TOROIDAL_LIFE_AUTOMATON_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tla_pkg.sv
package tla_pkg;

  localparam int ROWS  = 14;
  localparam int COLS  = 39;
  localparam int ROW_W = 4;
  localparam int COL_W = 6;
  localparam int GEN_W = 16;
  localparam int CNT_W = $clog2(ROWS);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_STEP  = 2'd2,
    OP_DUMP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  typedef logic [COLS-1:0] row_t;

  // Control broadcast to every row cell.
  typedef struct packed {
    logic             clr;
    logic             set;
    logic             shift;
    logic [CNT_W-1:0] row;
    logic [COL_W-1:0] col;
  } cell_ctl_t;

endpackage

### hw/rtl/tla_cell.sv
module tla_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tla_pkg::cell_ctl_t      ctl,
  input  logic [tla_pkg::CNT_W-1:0] cell_idx,
  input  tla_pkg::row_t           shift_in,
  output tla_pkg::row_t           row_q
);
  import tla_pkg::*;

  row_t row_r;
  row_t row_nxt;
  row_t col_hot;

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      col_hot[c] = (ctl.col == COL_W'(c));
    end
  end

  always_comb begin
    priority if (ctl.clr) begin
      row_nxt = '0;
    end else if (ctl.shift) begin
      row_nxt = shift_in;
    end else if (ctl.set && (ctl.row == cell_idx)) begin
      row_nxt = row_r | col_hot;
    end else begin
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_q = row_r;

endmodule

### hw/rtl/tla_rule.sv
module tla_rule (
  input  tla_pkg::row_t up,
  input  tla_pkg::row_t mid,
  input  tla_pkg::row_t dn,
  output tla_pkg::row_t nxt
);
  import tla_pkg::*;

  // One B3/S23 evaluator per column; columns wrap at both edges.
  for (genvar c = 0; c < COLS; c++) begin : g_col
    localparam int CL = (c == 0) ? COLS - 1 : c - 1;
    localparam int CR = (c == COLS - 1) ? 0 : c + 1;
    logic [3:0] n;

    assign n = 4'(up[CL]) + 4'(up[c]) + 4'(up[CR]) + 4'(mid[CL]) + 4'(mid[CR])
             + 4'(dn[CL]) + 4'(dn[c]) + 4'(dn[CR]);
    assign nxt[c] = (n == 4'd3) || (mid[c] && (n == 4'd2));
  end

endmodule

### hw/rtl/toroidal_life_automaton.sv
// Channel   Ports                                          Handshake
// command   in_opcode, in_cell_row, in_cell_col            start & !busy
// result    out_row_index, out_row_cells,                  out_valid, one cycle
//           out_changed_cells, out_generation, out_last_row
//
// Clear and set finish at the accepting edge; busy stays low, no beat.
// Step and dump walk all ROWS (14) rows: the grid circulates once around the
//   ring of row cells, one row a cycle passing the single rule evaluator.
// Each row beat appears in the cycle after its row is walked; last_row marks
//   the final beat. A new command may be taken during that final beat.
// Reset (synchronous, rst_n low) kills every cell and zeroes the counter.
// The receiver cannot stall; every beat is shown for one cycle only.
module toroidal_life_automaton (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_opcode,
  input  logic [tla_pkg::ROW_W-1:0]  in_cell_row,
  input  logic [tla_pkg::COL_W-1:0]  in_cell_col,
  output logic                       out_valid,
  output logic [tla_pkg::ROW_W-1:0]  out_row_index,
  output logic [tla_pkg::COLS-1:0]   out_row_cells,
  output logic [tla_pkg::COLS-1:0]   out_changed_cells,
  output logic [tla_pkg::GEN_W-1:0]  out_generation,
  output logic                       out_last_row
);
  import tla_pkg::*;
  `include "toroidal_life_automaton_assert.svh"

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             dump_r, dump_nxt;
  logic [GEN_W-1:0] gen_r, gen_nxt;
  row_t             prev_r;       // old value of the row walked last
  row_t             first_r;      // old value of row 0, lower neighbor of the last row
  logic             out_valid_r;
  logic [ROW_W-1:0] out_idx_r;
  row_t             out_cells_r;
  row_t             out_chg_r;
  logic [GEN_W-1:0] out_gen_r;
  logic             out_last_r;

  op_t              op;
  logic             accept;
  logic             walking;
  logic             at_last;
  cell_ctl_t        ctl;
  row_t             row_q [ROWS];
  row_t             up_row, mid_row, dn_row, rule_row, new_row, chg_row;

  assign op      = op_t'(in_opcode);
  assign accept  = start && (state_r == ST_IDLE);
  assign walking = (state_r == ST_WALK);
  assign at_last = (cnt_r == CNT_W'(ROWS - 1));
  assign busy    = walking;

  // Command decode, broadcast to all cells.
  always_comb begin
    ctl       = '0;
    ctl.clr   = accept && (op == OP_CLEAR);
    ctl.set   = accept && (op == OP_SET) && (32'(in_cell_row) < ROWS)
                && (32'(in_cell_col) < COLS);
    ctl.shift = walking;
    ctl.row   = CNT_W'(in_cell_row);
    ctl.col   = in_cell_col;
  end

  // Ring of row cells: each cell hands its row to the one below; the top
  // cell takes the freshly evaluated row.
  for (genvar i = 0; i < ROWS; i++) begin : g_cell
    row_t sh_in;
    if (i == ROWS - 1) begin : g_tail
      assign sh_in = new_row;
    end else begin : g_body
      assign sh_in = row_q[i+1];
    end
    tla_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .cell_idx (CNT_W'(i)),
      .shift_in (sh_in),
      .row_q    (row_q[i])
    );
  end

  // Neighbors of the row sitting in cell 0. Above: the untouched last row on
  // the first walk cycle, else the saved previous row. Below: cell 1, except
  // on the final row, where cell 1 already holds the new row 0.
  assign mid_row = row_q[0];
  assign up_row  = (cnt_r == '0) ? row_q[ROWS-1] : prev_r;
  assign dn_row  = at_last ? first_r : row_q[1];

  tla_rule u_rule (
    .up  (up_row),
    .mid (mid_row),
    .dn  (dn_row),
    .nxt (rule_row)
  );

  assign new_row = dump_r ? mid_row : rule_row;
  assign chg_row = dump_r ? {COLS{1'b1}} : (rule_row ^ mid_row);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dump_nxt  = dump_r;
    gen_nxt   = gen_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_CLEAR: gen_nxt = '0;
            OP_SET:   gen_nxt = gen_r;
            OP_STEP: begin
              gen_nxt   = gen_r + 1'b1;
              dump_nxt  = 1'b0;
              cnt_nxt   = '0;
              state_nxt = ST_WALK;
            end
            OP_DUMP: begin
              dump_nxt  = 1'b1;
              cnt_nxt   = '0;
              state_nxt = ST_WALK;
            end
            default: gen_nxt = gen_r;
          endcase
        end
      end
      ST_WALK: begin
        cnt_nxt = cnt_r + 1'b1;
        if (at_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      dump_r      <= 1'b0;
      gen_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dump_r      <= dump_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= walking;
      out_last_r  <= walking && at_last;
    end
  end

  // Payload registers: hold the walked row's result for one beat.
  always_ff @(posedge clk) begin
    if (walking) begin
      prev_r      <= mid_row;
      out_idx_r   <= ROW_W'(cnt_r);
      out_cells_r <= new_row;
      out_chg_r   <= chg_row;
      out_gen_r   <= gen_r;
      if (cnt_r == '0) begin
        first_r <= mid_row;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row_index     = out_idx_r;
  assign out_row_cells     = out_cells_r;
  assign out_changed_cells = out_chg_r;
  assign out_generation    = out_gen_r;
  assign out_last_row      = out_last_r;

  `TLA_ASSERT_IMP(a_last_has_valid, out_last_row, out_valid, "last_row without a beat")
  `TLA_ASSERT_IMP(a_last_ends_walk, out_last_row, !busy, "still busy after last row")
  `TLA_ASSERT_NEXT(a_beat_follows_walk, busy, out_valid, "walk cycle produced no beat")
  `TLA_ASSERT_NEXT(a_no_beat_when_idle, !busy, !out_valid, "beat without a walk cycle")
  `TLA_ASSERT_NEXT(a_walk_start_row0, start && !busy && (in_opcode == OP_STEP),
                   busy && (cnt_r == '0), "step did not start at row 0")

endmodule
